/* design/stbs_pkg.sv */
`timescale 1ns / 1ps

package stbs_pkg;

    // default sizes of the table
    localparam int TABLE_DEPTH_DEF = 8192;
    localparam int KEY_BITS_DEF    = 32;

    // fixed port widths
    localparam int COUNT_W = 14;
    localparam int INDEX_W = 13;
    localparam int KEY_W   = 32;

    // controller to datapath
    typedef struct packed {
        logic wr_en;     // write one table entry from the input word
        logic start;     // load key and bounds for a new search
        logic probe;     // first table read from the loaded bounds
        logic step;      // compare read data and narrow the bounds
        logic load_out;  // move the search result into the output register
    } stbs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;     // clamped entry count is zero
        logic cont;      // search goes on after this compare
    } stbs_stat_t;

endpackage

/* design/sorted_table_binary_search_top.sv */
`timescale 1ns / 1ps

// Sorted key table with binary search. A word with s_mode low stores s_key at
// s_entry_index (indexes at or above TABLE_DEPTH are dropped) and gives no
// result; the block stays ready. A word with s_mode high searches the first
// entry_count entries (clamped to TABLE_DEPTH) and gives one result word:
// m_found and, on a hit, m_match_index, else zero. Software keeps the table in
// ascending order; an empty table or a key below the first entry reports not
// found. A search does accept and first read, then one table probe per cycle
// through the registered read port of the key RAM, then the result load once
// the output register is free. The next word is taken once the result sits in
// the output register. The user must write entry_count through cfg_wr_en /
// cfg_wr_data only while the block is idle, which the block does not enforce;
// the table has no reset and must be written before it is searched.
module sorted_table_binary_search_top
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [INDEX_W-1:0] s_entry_index,
    input  logic [KEY_W-1:0]   s_key,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic [INDEX_W-1:0] m_match_index
);

    // command and status between sequencer and datapath
    stbs_cmd_t  cmd;
    stbs_stat_t stat;

    // sequencer: accept, probe, compare loop, result handoff
    stbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: count register, key ram, search window, result register
    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_entry_index (s_entry_index),
        .s_key         (s_key),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_found       (m_found),
        .m_match_index (m_match_index)
    );

endmodule

/* design/stbs_ram.sv */
`timescale 1ns / 1ps

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/stbs_ctrl.sv */
`timescale 1ns / 1ps

module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_mode,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  stbs_stat_t stat,
    output stbs_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PROBE  = 4'b0010,
        ST_CMP    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.wr_en    = accept && !s_mode;
        cmd.start    = accept && s_mode;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_mode) begin
                    state_next = stat.empty ? ST_FINISH : ST_PROBE;
                end
            end
            ST_PROBE: begin
                cmd.probe  = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.step = 1'b1;
                if (!stat.cont) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/stbs_dp.sv */
`timescale 1ns / 1ps

module stbs_dp
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  stbs_cmd_t          cmd,
    output stbs_stat_t         stat,
    input  logic [INDEX_W-1:0] s_entry_index,
    input  logic [KEY_W-1:0]   s_key,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    output logic               m_found,
    output logic [INDEX_W-1:0] m_match_index
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam logic [31:0] DEPTH32 = TABLE_DEPTH;
    localparam logic [CW-1:0] ONE = {{(CW-1){1'b0}}, 1'b1};

    logic [COUNT_W-1:0]  count_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CW-1:0]       lo_reg, hx_reg;     // search window [lo, hx)
    logic [AW-1:0]       mid_reg;
    logic                found_reg;
    logic [AW-1:0]       hit_idx_reg;
    logic                m_found_reg;
    logic [INDEX_W-1:0]  m_index_reg;

    logic [31:0]         count32, waddr32, mid32;
    logic [CW-1:0]       n_entries;
    logic                wr_ok;
    logic [KEY_BITS-1:0] key_in;
    logic [63:0]         key64;
    logic [AW-1:0]       raddr;
    logic [KEY_BITS-1:0] rdata;

    logic [CW-1:0] mid_ext, m1;
    logic [CW-1:0] diff0, mid0_w, diff_a, mid_a_w, diff_b, mid_b_w;
    logic          hit, lt;

    // clamp the entry count to the table depth
    assign count32   = 32'(count_reg);
    assign n_entries = (count32 > DEPTH32) ? DEPTH32[CW-1:0] : count32[CW-1:0];
    assign stat.empty = (n_entries == '0);

    // write side
    assign waddr32 = 32'(s_entry_index);
    assign wr_ok   = cmd.wr_en && (waddr32 < DEPTH32);
    assign key64   = 64'(s_key);
    assign key_in  = key64[KEY_BITS-1:0];

    // midpoints: from the loaded window, after a step up, after a step down
    assign mid_ext = {1'b0, mid_reg};
    assign m1      = mid_ext + ONE;
    assign diff0   = hx_reg - lo_reg - ONE;
    assign mid0_w  = lo_reg + (diff0 >> 1);
    assign diff_a  = hx_reg - m1 - ONE;
    assign mid_a_w = m1 + (diff_a >> 1);
    assign diff_b  = mid_ext - lo_reg - ONE;
    assign mid_b_w = lo_reg + (diff_b >> 1);

    assign hit = (rdata == key_reg);
    assign lt  = (rdata < key_reg);
    assign stat.cont = !hit && (lt ? (m1 < hx_reg) : (lo_reg < mid_ext));

    always_comb begin
        if (cmd.probe) begin
            raddr = mid0_w[AW-1:0];
        end else if (lt) begin
            raddr = mid_a_w[AW-1:0];
        end else begin
            raddr = mid_b_w[AW-1:0];
        end
    end

    stbs_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_ok),
        .waddr (waddr32[AW-1:0]),
        .wdata (key_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg     <= key_in;
            lo_reg      <= '0;
            hx_reg      <= n_entries;
            found_reg   <= 1'b0;
            hit_idx_reg <= '0;
        end
        if (cmd.probe) begin
            mid_reg <= mid0_w[AW-1:0];
        end
        if (cmd.step) begin
            if (hit) begin
                found_reg   <= 1'b1;
                hit_idx_reg <= mid_reg;
            end else if (lt) begin
                lo_reg  <= m1;
                mid_reg <= mid_a_w[AW-1:0];
            end else begin
                hx_reg  <= mid_ext;
                mid_reg <= mid_b_w[AW-1:0];
            end
        end
        if (cmd.load_out) begin
            m_found_reg <= found_reg;
            m_index_reg <= mid32[INDEX_W-1:0];
        end
    end

    assign mid32 = 32'(hit_idx_reg);

    assign m_found       = m_found_reg;
    assign m_match_index = m_index_reg;

endmodule
